FILE: sv/pntag_pkg.sv
package pntag_pkg;

    localparam int MAX_DIMS = 8;
    localparam int DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W    = $clog2(MAX_DIMS + 1);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_STEP  = 2'd2;

    localparam logic [2:0] REG_DIMS_IN_USE     = 3'd0;
    localparam logic [2:0] REG_START_PAGE      = 3'd1;
    localparam logic [2:0] REG_TILES_FOR_CORE  = 3'd2;
    localparam logic [2:0] REG_TILES_PER_GROUP = 3'd3;
    localparam logic [2:0] REG_ROW_TILES_HERE  = 3'd4;
    localparam logic [2:0] REG_ROW_TILES_TOTAL = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  dim_index;
        logic [31:0] extent;
        logic [31:0] skip_pages;
        logic [31:0] first_index;
    } in_item_t;

    typedef struct packed {
        logic [31:0] page_id;
        logic        do_read;
        logic [15:0] slot;
        logic        group_end;
        logic        last_tile;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  dims_in_use;
        logic [31:0] start_page;
        logic [31:0] tiles_for_core;
        logic [15:0] tiles_per_group;
        logic [15:0] row_tiles_here;
        logic [15:0] row_tiles_total;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic start;
        logic step;
        logic carry;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       run_done;
        logic       chain_off;
        logic       carry_more;
    } status_t;

endpackage

FILE: sv/pntag_ctrl.sv
module pntag_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pntag_pkg::status_t status,
    output pntag_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CARRY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.capture = in_valid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (status.func)
                    pntag_pkg::FUNC_LOAD:
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    pntag_pkg::FUNC_BEGIN:
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    pntag_pkg::FUNC_STEP:
                    begin
                        if (status.run_done)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            cmd.step   = 1'b1;
                            state_next = status.chain_off ? ST_IDLE : ST_CARRY;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CARRY:
            begin
                cmd.carry = 1'b1;
                if (!status.carry_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/pntag_dp.sv
module pntag_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pntag_pkg::cfg_t      cfg,
    input  pntag_pkg::in_item_t  in_data,
    input  pntag_pkg::cmd_t      cmd,
    output pntag_pkg::status_t   status,
    output pntag_pkg::out_item_t out_data
);

    pntag_pkg::in_item_t  item_reg;
    pntag_pkg::out_item_t out_reg;

    logic [31:0] extent_tab_reg [pntag_pkg::MAX_DIMS];
    logic [31:0] skip_tab_reg   [pntag_pkg::MAX_DIMS];
    logic [31:0] index_tab_reg  [pntag_pkg::MAX_DIMS];

    logic [31:0]               page_reg;
    logic [31:0]               page_next;
    logic [31:0]               done_reg;
    logic [31:0]               done_next;
    logic [15:0]               slot_reg;
    logic [15:0]               slot_next;
    logic [pntag_pkg::CNT_W-1:0] dim_reg;
    logic [pntag_pkg::CNT_W-1:0] dim_next;

    logic [pntag_pkg::CNT_W-1:0] dims_n;
    logic [pntag_pkg::DIM_W-1:0] load_ix;
    logic                        load_ok;
    logic [pntag_pkg::DIM_W-1:0] cur_ix;
    logic [31:0]                 cur_inc;
    logic                        cur_wrap;

    logic [31:0] extra;
    logic [31:0] limit;
    logic        rd;
    logic [31:0] done_inc;
    logic        last;
    logic [16:0] group;
    logic [16:0] slot_inc;
    logic        gend;

    // active dimension count, clamped
    assign dims_n = (32'(cfg.dims_in_use) > 32'(pntag_pkg::MAX_DIMS))
                    ? pntag_pkg::CNT_W'(pntag_pkg::MAX_DIMS)
                    : pntag_pkg::CNT_W'(cfg.dims_in_use);

    assign load_ok = 32'(item_reg.dim_index) < 32'(pntag_pkg::MAX_DIMS);
    assign load_ix = pntag_pkg::DIM_W'(item_reg.dim_index);

    // one dimension of the carry chain per cycle
    assign cur_ix   = dim_reg[pntag_pkg::DIM_W-1:0];
    assign cur_inc  = index_tab_reg[cur_ix] + 32'd1;
    assign cur_wrap = (cur_inc == extent_tab_reg[cur_ix]);

    // padding test on the innermost dimension
    assign extra = 32'(cfg.row_tiles_total) - 32'(cfg.row_tiles_here);
    assign limit = extent_tab_reg[0] - extra;
    assign rd    = !(index_tab_reg[0] >= limit);

    assign done_inc = done_reg + 32'd1;
    assign last     = (done_inc == cfg.tiles_for_core);
    assign group    = (cfg.tiles_per_group == 16'd0) ? 17'd1 : 17'(cfg.tiles_per_group);
    assign slot_inc = 17'(slot_reg) + 17'd1;
    assign gend     = (slot_inc >= group) || last;

    assign status.func       = item_reg.func;
    assign status.run_done   = (done_reg >= cfg.tiles_for_core);
    assign status.chain_off  = (dims_n == '0);
    assign status.carry_more = cur_wrap && ((dim_reg + pntag_pkg::CNT_W'(1)) < dims_n);

    assign out_data = out_reg;

    always_comb
    begin
        page_next = page_reg;
        done_next = done_reg;
        slot_next = slot_reg;
        dim_next  = dim_reg;
        if (cmd.start)
        begin
            page_next = cfg.start_page;
            done_next = '0;
            slot_next = '0;
        end
        else if (cmd.step)
        begin
            page_next = page_reg + 32'd1;
            done_next = done_inc;
            slot_next = gend ? 16'd0 : slot_inc[15:0];
            dim_next  = '0;
        end
        else if (cmd.carry)
        begin
            if (cur_wrap)
            begin
                page_next = page_reg + skip_tab_reg[cur_ix];
            end
            dim_next = dim_reg + pntag_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= '0;
            done_reg <= '0;
            slot_reg <= '0;
            dim_reg  <= '0;
        end
        else
        begin
            page_reg <= page_next;
            done_reg <= done_next;
            slot_reg <= slot_next;
            dim_reg  <= dim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.step)
        begin
            out_reg.page_id   <= page_reg;
            out_reg.do_read   <= rd;
            out_reg.slot      <= slot_reg;
            out_reg.group_end <= gend;
            out_reg.last_tile <= last;
        end
        if (cmd.load && load_ok)
        begin
            extent_tab_reg[load_ix] <= item_reg.extent;
            skip_tab_reg[load_ix]   <= item_reg.skip_pages;
            index_tab_reg[load_ix]  <= item_reg.first_index;
        end
        else if (cmd.carry)
        begin
            index_tab_reg[cur_ix] <= cur_wrap ? 32'd0 : cur_inc;
        end
    end

endmodule

FILE: sv/padded_nd_tile_address_generator.sv
// Walks the tiles of a padded N-dimensional slice, one beat in and at most one beat
// out per item. Load beats fill one dimension entry, a begin beat restarts the page
// counter at start_page, and each step beat returns the tile's page, read/skip flag,
// group slot, group end and last tile marks, then advances the page and ripples the
// index carry. The carry walks one dimension per cycle in a shared incrementer, and
// a tile step's carry visits 1 to dims_in_use dimensions (at most 8, and none when
// dims_in_use is 0); load, begin and ignored step beats have no carry. A step waits
// while a previous result beat is still held. Configuration must be written over the
// APB port only while the block is idle; the block itself does not enforce this.
module padded_nd_tile_address_generator
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pntag_pkg::ADDR_W-1:0]     paddr,
    input  logic [pntag_pkg::DATA_W-1:0]     pwdata,
    output logic [pntag_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  pntag_pkg::in_item_t              in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pntag_pkg::out_item_t             out_data
);

    pntag_pkg::cfg_t    cfg_reg;
    pntag_pkg::cmd_t    cmd;
    pntag_pkg::status_t status;
    logic               wr_en;
    logic [2:0]         reg_ix;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign reg_ix = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dims_in_use     <= 4'd1;
            cfg_reg.start_page      <= '0;
            cfg_reg.tiles_for_core  <= '0;
            cfg_reg.tiles_per_group <= 16'd1;
            cfg_reg.row_tiles_here  <= '0;
            cfg_reg.row_tiles_total <= '0;
        end
        else if (wr_en)
        begin
            case (reg_ix)
                pntag_pkg::REG_DIMS_IN_USE:     cfg_reg.dims_in_use     <= pwdata[3:0];
                pntag_pkg::REG_START_PAGE:      cfg_reg.start_page      <= pwdata;
                pntag_pkg::REG_TILES_FOR_CORE:  cfg_reg.tiles_for_core  <= pwdata;
                pntag_pkg::REG_TILES_PER_GROUP: cfg_reg.tiles_per_group <= pwdata[15:0];
                pntag_pkg::REG_ROW_TILES_HERE:  cfg_reg.row_tiles_here  <= pwdata[15:0];
                pntag_pkg::REG_ROW_TILES_TOTAL: cfg_reg.row_tiles_total <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_ix)
            pntag_pkg::REG_DIMS_IN_USE:     prdata = 32'(cfg_reg.dims_in_use);
            pntag_pkg::REG_START_PAGE:      prdata = cfg_reg.start_page;
            pntag_pkg::REG_TILES_FOR_CORE:  prdata = cfg_reg.tiles_for_core;
            pntag_pkg::REG_TILES_PER_GROUP: prdata = 32'(cfg_reg.tiles_per_group);
            pntag_pkg::REG_ROW_TILES_HERE:  prdata = 32'(cfg_reg.row_tiles_here);
            pntag_pkg::REG_ROW_TILES_TOTAL: prdata = 32'(cfg_reg.row_tiles_total);
            default:                        prdata = '0;
        endcase
    end

    pntag_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pntag_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

FILE: sv/pntag_checker.sv
module pntag_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input pntag_pkg::out_item_t out_data
);

    // held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result beat changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while busy");

    // a result never appears in the cycle right after an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result beat too early");

    // final tile always closes its group
    a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.last_tile || out_data.group_end))
        else $error("last tile without group end");

endmodule

bind padded_nd_tile_address_generator pntag_checker u_pntag_checker (.*);

FILE: tb/sv/tb_padded_nd_tile_address_generator.sv
module tb_padded_nd_tile_address_generator;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    class tile_scoreboard;
        logic [31:0]          extent_tab [pntag_pkg::MAX_DIMS];
        logic [31:0]          skip_tab [pntag_pkg::MAX_DIMS];
        logic [31:0]          index_tab [pntag_pkg::MAX_DIMS];
        logic [31:0]          page_ctr;
        logic [31:0]          tiles_done;
        logic [15:0]          grp_slot;
        pntag_pkg::cfg_t      cfg;
        pntag_pkg::out_item_t tile_q [$];
        int                   errors;
        int                   tiles;
        int                   skipped;
        int                   group_ends;
        int                   finals;

        function new();
            cfg = '0;
            cfg.dims_in_use = 4'd1;
            cfg.tiles_per_group = 16'd1;
            page_ctr = '0;
            tiles_done = '0;
            grp_slot = '0;
            errors = 0;
            tiles = 0;
            skipped = 0;
            group_ends = 0;
            finals = 0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [31:0] value);
            case (addr)
                pntag_pkg::REG_DIMS_IN_USE:     cfg.dims_in_use = value[3:0];
                pntag_pkg::REG_START_PAGE:      cfg.start_page = value;
                pntag_pkg::REG_TILES_FOR_CORE:  cfg.tiles_for_core = value;
                pntag_pkg::REG_TILES_PER_GROUP: cfg.tiles_per_group = value[15:0];
                pntag_pkg::REG_ROW_TILES_HERE:  cfg.row_tiles_here = value[15:0];
                pntag_pkg::REG_ROW_TILES_TOTAL: cfg.row_tiles_total = value[15:0];
                default: ;
            endcase
        endfunction

        // returns 0 when the block ignores the beat
        function bit note_input(pntag_pkg::in_item_t beat);
            logic [31:0]          limit;
            logic [31:0]          span;
            logic [31:0]          next_slot;
            logic [15:0]          cur_slot;
            int                   chain;
            pntag_pkg::out_item_t tile;
            case (beat.func)
                pntag_pkg::FUNC_LOAD:
                begin
                    extent_tab[beat.dim_index] = beat.extent;
                    skip_tab[beat.dim_index] = beat.skip_pages;
                    index_tab[beat.dim_index] = beat.first_index;
                    return 1'b1;
                end
                pntag_pkg::FUNC_BEGIN:
                begin
                    page_ctr = cfg.start_page;
                    tiles_done = '0;
                    grp_slot = '0;
                    return 1'b1;
                end
                pntag_pkg::FUNC_STEP: ;
                default: return 1'b0;
            endcase
            if (tiles_done >= cfg.tiles_for_core)
                return 1'b0;
            limit = extent_tab[0] - (32'(cfg.row_tiles_total) - 32'(cfg.row_tiles_here));
            tile.page_id = page_ctr;
            tile.do_read = !(index_tab[0] >= limit);
            cur_slot = grp_slot;
            tiles_done = tiles_done + 32'd1;
            span = (cfg.tiles_per_group == 16'd0) ? 32'd1 : 32'(cfg.tiles_per_group);
            next_slot = 32'(cur_slot) + 32'd1;
            tile.slot = cur_slot;
            tile.last_tile = (tiles_done == cfg.tiles_for_core);
            tile.group_end = (next_slot >= span) || tile.last_tile;
            tile_q = {tile_q, tile};
            grp_slot = tile.group_end ? 16'd0 : next_slot[15:0];
            page_ctr = page_ctr + 32'd1;
            // index carry across the dimensions in use
            chain = (cfg.dims_in_use > pntag_pkg::MAX_DIMS) ? pntag_pkg::MAX_DIMS
                                                            : int'(cfg.dims_in_use);
            for (int j = 0; j < chain; j++)
            begin
                index_tab[j] = index_tab[j] + 32'd1;
                if (index_tab[j] != extent_tab[j])
                    break;
                index_tab[j] = '0;
                page_ctr = page_ctr + skip_tab[j];
            end
            return 1'b1;
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t mismatch %s expected %h actual %h", $time, field, want, got);
        endfunction

        function void check_result(pntag_pkg::out_item_t got);
            pntag_pkg::out_item_t want;
            if (tile_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat page_id %h", $time, got.page_id);
                return;
            end
            want = tile_q.pop_front();
            tiles++;
            if (!want.do_read)
                skipped++;
            if (want.group_end)
                group_ends++;
            if (want.last_tile)
                finals++;
            if (got.page_id !== want.page_id)
                report("page_id", want.page_id, got.page_id);
            if (got.do_read !== want.do_read)
                report("do_read", 32'(want.do_read), 32'(got.do_read));
            if (got.slot !== want.slot)
                report("slot", 32'(want.slot), 32'(got.slot));
            if (got.group_end !== want.group_end)
                report("group_end", 32'(want.group_end), 32'(got.group_end));
            if (got.last_tile !== want.last_tile)
                report("last_tile", 32'(want.last_tile), 32'(got.last_tile));
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [pntag_pkg::ADDR_W-1:0]   paddr;
    logic [pntag_pkg::DATA_W-1:0]   pwdata;
    logic [pntag_pkg::DATA_W-1:0]   prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_ready;
    pntag_pkg::in_item_t            in_data;
    logic                           out_valid;
    logic                           out_ready;
    pntag_pkg::out_item_t           out_data;

    tile_scoreboard sb = new();
    int             idle_pct;
    int             counted;
    int             phases;
    int             cycles = 0;

    padded_nd_tile_address_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[padded_nd_tile_address_generator] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    function automatic int idle_gap();
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic pntag_pkg::in_item_t ctl_beat(logic [1:0] f);
        pntag_pkg::in_item_t beat;
        beat.func = f;
        beat.dim_index = 3'($urandom);
        beat.extent = $urandom;
        beat.skip_pages = $urandom;
        beat.first_index = $urandom;
        return beat;
    endfunction

    function automatic pntag_pkg::in_item_t load_beat(logic [2:0] dim, logic [31:0] ext,
                                                      logic [31:0] skp, logic [31:0] first);
        pntag_pkg::in_item_t beat;
        beat.func = pntag_pkg::FUNC_LOAD;
        beat.dim_index = dim;
        beat.extent = ext;
        beat.skip_pages = skp;
        beat.first_index = first;
        return beat;
    endfunction

    function automatic pntag_pkg::in_item_t random_beat();
        int                  r;
        logic [31:0]         ext;
        pntag_pkg::in_item_t beat;
        r = $urandom_range(0, 99);
        beat = ctl_beat(pntag_pkg::FUNC_STEP);
        if (r < 6)
            beat.func = pntag_pkg::FUNC_BEGIN;
        else if (r < 14)
        begin
            ext = $urandom_range(1, 5);
            beat = load_beat(3'($urandom), ext, $urandom, $urandom_range(0, ext - 1));
        end
        else if (r < 17)
            beat.func = pntag_pkg::FUNC_LOAD;
        else if (r < 20)
            beat.func = FUNC_UNUSED;
        return beat;
    endfunction

    // setup and access cycles, then an idle wait with psel low so psel never toggles within a step
    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {addr, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(addr, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(logic [3:0] dims, logic [31:0] first_page,
                                logic [31:0] tile_count, logic [15:0] group,
                                logic [15:0] here, logic [15:0] total);
        apb_write(pntag_pkg::REG_DIMS_IN_USE, 32'(dims));
        apb_write(pntag_pkg::REG_START_PAGE, first_page);
        apb_write(pntag_pkg::REG_TILES_FOR_CORE, tile_count);
        apb_write(pntag_pkg::REG_TILES_PER_GROUP, 32'(group));
        apb_write(pntag_pkg::REG_ROW_TILES_HERE, 32'(here));
        apb_write(pntag_pkg::REG_ROW_TILES_TOTAL, 32'(total));
    endtask

    task automatic random_settings();
        logic [3:0]  dims;
        logic [31:0] first_page;
        logic [31:0] tile_count;
        logic [15:0] group;
        logic [15:0] here;
        logic [15:0] total;
        case ($urandom_range(0, 9))
            0: dims = 4'd0;
            1: dims = 4'($urandom_range(9, 15));
            default: dims = 4'($urandom_range(1, 8));
        endcase
        first_page = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + 32'($urandom_range(0, 15))
                                                 : 32'($urandom);
        case ($urandom_range(0, 9))
            0: tile_count = 32'd0;
            1: tile_count = 32'hFFFF_FFFF;
            default: tile_count = 32'($urandom_range(4, 48));
        endcase
        case ($urandom_range(0, 9))
            0: group = 16'd0;
            1: group = 16'hFFFF;
            2: group = 16'($urandom);
            default: group = 16'($urandom_range(1, 8));
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            here = 16'($urandom);
            total = 16'($urandom);
        end
        else
        begin
            here = 16'($urandom_range(0, 4));
            total = 16'($urandom_range(0, 4));
        end
        program_regs(dims, first_page, tile_count, group, here, total);
    endtask

    task automatic send_beat(pntag_pkg::in_item_t beat);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        void'(sb.note_input(beat));
        counted++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.tile_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int gap;
        int run;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            gap = idle_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        idle_pct = 40;
        counted = 0;
        phases = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full carry chain, page wrap, padding skip, group and final tile marks
        program_regs(4'd8, 32'hFFFF_FFFE, 32'd6, 16'd4, 16'd2, 16'd3);
        send_beat(load_beat(3'd0, 32'd3, 32'hFFFF_FFFF, 32'd0));
        for (int d = 1; d < pntag_pkg::MAX_DIMS - 1; d++)
            send_beat(load_beat(3'(d), 32'd1, $urandom, 32'd0));
        send_beat(load_beat(3'(pntag_pkg::MAX_DIMS - 1), 32'hFFFF_FFFF, 32'd0,
                            32'hFFFF_FFFE));
        send_beat(ctl_beat(pntag_pkg::FUNC_BEGIN));
        send_beat(ctl_beat(FUNC_UNUSED));
        repeat (7) send_beat(ctl_beat(pntag_pkg::FUNC_STEP));
        settle();

        // carry chain off, group size zero, row padding count wrapping
        program_regs(4'd0, 32'd0, 32'd3, 16'd0, 16'hFFFF, 16'd0);
        send_beat(ctl_beat(pntag_pkg::FUNC_BEGIN));
        repeat (4) send_beat(ctl_beat(pntag_pkg::FUNC_STEP));
        settle();

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(30, 60);
            random_settings();
            // some phases keep the running walk to change group size mid run
            if ($urandom_range(0, 3) != 0)
                send_beat(ctl_beat(pntag_pkg::FUNC_BEGIN));
            repeat ($urandom_range(50, 90)) send_beat(random_beat());
            settle();
            phases++;
        end

        $display("checked %0d tile beats: %0d padding skips, %0d group ends, %0d final tiles",
                 sb.tiles, sb.skipped, sb.group_ends, sb.finals);
        $display("%0d random setting phases after the directed walks, %0d mismatches",
                 phases, sb.errors);
        if (sb.errors == 0 && sb.tile_q.size() == 0)
            $display("[padded_nd_tile_address_generator] OK");
        else
            $display("[padded_nd_tile_address_generator] ERROR");
        $finish;
    end

endmodule
